/* design/ttb_pkg.sv */
`timescale 1ns / 1ps
package ttb_pkg;

   // register indexes of the configuration port
   localparam int unsigned CSR_MIN_LENGTH = 0;
   localparam logic [15:0] MIN_LENGTH_RESET = 16'd7;

   localparam int unsigned UNIT_FRAC_BITS_DEF = 14;

   // shared multiplier operand and product widths
   localparam int unsigned MUL_A_W = 33;
   localparam int unsigned MUL_B_W = 32;
   localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

   // shared divider: dividend, divisor, saturated quotient
   localparam int unsigned DIV_NUM_W = 72;
   localparam int unsigned DIV_DEN_W = 42;
   localparam int unsigned DIV_Q_W   = 31;
   localparam int unsigned DIV_STEPS = 32;

   localparam int unsigned UV_FRAC = 16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SQ_A,
      ST_SQ_B,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_UNIT_GO,
      ST_UNIT_WAIT,
      ST_OUT
   } state_type;

endpackage

/* design/ttb_mul.sv */
`timescale 1ns / 1ps
module ttb_mul (
   input  logic                                   clock,
   input  logic signed [ttb_pkg::MUL_A_W-1:0]     a,
   input  logic signed [ttb_pkg::MUL_B_W-1:0]     b,
   output logic signed [ttb_pkg::MUL_P_W-1:0]     prod
);
   import ttb_pkg::*;

   logic signed [MUL_P_W-1:0] prod_ff;
   logic signed [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(a) * MUL_P_W'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

/* design/ttb_div.sv */
`timescale 1ns / 1ps
module ttb_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ttb_pkg::DIV_NUM_W-1:0]   num,
   input  logic [ttb_pkg::DIV_DEN_W-1:0]   den,
   output logic                            done,
   output logic [ttb_pkg::DIV_Q_W-1:0]     quot
);
   import ttb_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic                 ovf_ff, ovf_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_STEPS-1:0] low_ff, low_in;
   logic [DIV_STEPS-1:0] q_ff, q_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 high_ovf;

   // top part of the dividend must stay below the divisor, else saturate
   assign high_ovf = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_STEPS]) >= den;
   assign trial    = {rem_ff, low_ff[DIV_STEPS-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         ovf_in  = high_ovf;
         rem_in  = high_ovf ? '0 : DIV_DEN_W'(num[DIV_NUM_W-1:DIV_STEPS]);
         den_in  = den;
         low_in  = num[DIV_STEPS-1:0];
         q_in    = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_in = DIV_DEN_W'(trial);
            q_in   = {q_ff[DIV_STEPS-2:0], 1'b0};
         end
         low_in = {low_ff[DIV_STEPS-2:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      ovf_ff <= ovf_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = (ovf_ff || q_ff[DIV_STEPS-1]) ? {DIV_Q_W{1'b1}} : q_ff[DIV_Q_W-1:0];

endmodule

/* design/ttb_sqrt.sv */
`timescale 1ns / 1ps
module ttb_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   import ttb_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] bit_ff, bit_in;
   logic [63:0] trial;

   assign trial = r_ff + bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         x_in    = radicand;
         r_in    = '0;
         bit_in  = 64'd1 << 62;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in = x_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[31:0];

endmodule

/* design/triangle_tangent_bitangent.sv */
`timescale 1ns / 1ps
// Sequence: the first two vertices of a triangle are accepted and held. The third vertex
// starts the multiplier steps, then per vector three divisions, three squarings, a square
// root and three normalizing divisions (none if the vector is zeroed); the result
// transaction is then offered (straight after the multiplier steps if degenerate).
// Throughput: one triangle at a time, set by the single 1-bit-per-cycle divider.
// Reset (synchronous, active high) clears the corner count, sequencer and min_length (to 7).
module triangle_tangent_bitangent #(
   parameter int unsigned UNIT_FRAC_BITS = ttb_pkg::UNIT_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // vertex transactions
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [19:0] req_tex_u,
   input  logic signed [19:0] req_tex_v,
   // result transactions
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_tangent_x,
   output logic signed [15:0] rsp_tangent_y,
   output logic signed [15:0] rsp_tangent_z,
   output logic signed [15:0] rsp_bitangent_x,
   output logic signed [15:0] rsp_bitangent_y,
   output logic signed [15:0] rsp_bitangent_z,
   output logic               rsp_uv_degenerate,
   output logic               rsp_tangent_zeroed,
   output logic               rsp_bitangent_zeroed,
   // configuration
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import ttb_pkg::*;

   state_type state_ff, state_in;

   logic [1:0]  count_ff, count_in;
   logic [15:0] min_len_ff, min_len_in;
   logic [3:0]  op_ff, op_in;
   logic [1:0]  comp_ff, comp_in;
   logic        vec_ff, vec_in;

   // held corners
   logic signed [31:0] pos0_ff [3], pos0_in [3];
   logic signed [31:0] pos1_ff [3], pos1_in [3];
   logic signed [19:0] u0_ff, u0_in, v0_ff, v0_in, u1_ff, u1_in, v1_ff, v1_in;

   // edges and UV deltas of the current triangle
   logic signed [32:0] e1_ff [3], e1_in [3];
   logic signed [32:0] e2_ff [3], e2_in [3];
   logic signed [20:0] s1_ff, s1_in, t1_ff, t1_in, s2_ff, s2_in, t2_ff, t2_in;

   logic signed [55:0] acc_ff, acc_in;
   logic signed [55:0] num_ff [6], num_in [6];
   logic signed [43:0] det_ff, det_in;
   logic [DIV_Q_W-1:0] mag_ff [3], mag_in [3];
   logic [63:0]        sum_ff, sum_in;
   logic [31:0]        len_ff, len_in;
   logic [1:0]         zflag_ff, zflag_in;
   logic               deg_ff, deg_in;
   logic [15:0]        out_ff [6], out_in [6];

   logic                      req_accept, rsp_accept, csr_write;
   logic                      third;
   logic [2:0]                pair_sel;
   logic                      odd_op;
   logic [1:0]                lane;
   logic [2:0]                slot;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_prod;
   logic signed [55:0]        acc_diff;
   logic [55:0]               num_abs;
   logic [DIV_DEN_W-1:0]      det_abs;
   logic                      slot_neg;
   logic [DIV_NUM_W-1:0]      div_num;
   logic [DIV_DEN_W-1:0]      div_den;
   logic [DIV_Q_W-1:0]        div_quot;
   logic [31:0]               sqrt_root;
   logic [15:0]               unit_val;
   logic                      last_comp;
   logic                      div_start, div_done, sqrt_start, sqrt_done;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign csr_write  = psel && penable && pwrite && pready;
   assign third      = (count_ff >= 2'd2);

   assign pair_sel  = op_ff[3:1];
   assign odd_op    = op_ff[0];
   assign slot      = vec_ff ? 3'(comp_ff) + 3'd3 : 3'(comp_ff);
   assign last_comp = (comp_ff == 2'd2);
   assign acc_diff  = acc_ff - 56'(mul_prod);
   assign num_abs   = num_ff[slot][55] ? 56'(-num_ff[slot]) : 56'(num_ff[slot]);
   assign det_abs   = det_ff[43] ? DIV_DEN_W'(-det_ff) : DIV_DEN_W'(det_ff);
   assign slot_neg  = num_ff[slot][55] ^ det_ff[43];
   assign unit_val  = slot_neg ? 16'(16'd0 - div_quot[15:0]) : div_quot[15:0];

   // shared multiplier operand select: det, tangent and bitangent numerators,
   // then squared magnitudes
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      lane  = 2'd0;
      if (state_ff == ST_SQ_A || state_ff == ST_SQ_B) begin
         mul_a = MUL_A_W'(mag_ff[comp_ff]);
         mul_b = MUL_B_W'(mag_ff[comp_ff]);
      end else if (pair_sel == 3'd0) begin
         mul_a = odd_op ? MUL_A_W'(s2_ff) : MUL_A_W'(s1_ff);
         mul_b = odd_op ? MUL_B_W'(t1_ff) : MUL_B_W'(t2_ff);
      end else if (pair_sel <= 3'd3) begin
         lane  = 2'(pair_sel - 3'd1);
         mul_a = odd_op ? MUL_A_W'(e2_ff[lane]) : MUL_A_W'(e1_ff[lane]);
         mul_b = odd_op ? MUL_B_W'(t1_ff) : MUL_B_W'(t2_ff);
      end else if (pair_sel <= 3'd6) begin
         lane  = 2'(pair_sel - 3'd4);
         mul_a = odd_op ? MUL_A_W'(e1_ff[lane]) : MUL_A_W'(e2_ff[lane]);
         mul_b = odd_op ? MUL_B_W'(s2_ff) : MUL_B_W'(s1_ff);
      end
   end

   // shared divider operands: scaled component, or unit normalization
   always_comb begin
      if (state_ff == ST_UNIT_GO) begin
         div_num = (DIV_NUM_W'(mag_ff[comp_ff]) << UNIT_FRAC_BITS) +
                   DIV_NUM_W'(len_ff[31:1]);
         div_den = DIV_DEN_W'(len_ff);
      end else begin
         div_num = {num_abs, UV_FRAC'(0)};
         div_den = det_abs;
      end
   end

   ttb_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod)
   );

   ttb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   ttb_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sum_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_accept && third) state_in = ST_MUL_A;
         ST_MUL_A:     state_in = ST_MUL_B;
         ST_MUL_B: begin
            if (op_ff == 4'd13) state_in = (det_ff == '0) ? ST_OUT : ST_DIV_GO;
            else state_in = ST_MUL_A;
         end
         ST_DIV_GO:    state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:  if (div_done) state_in = last_comp ? ST_SQ_A : ST_DIV_GO;
         ST_SQ_A:      state_in = ST_SQ_B;
         ST_SQ_B:      state_in = last_comp ? ST_SQRT_GO : ST_SQ_A;
         ST_SQRT_GO:   state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT: if (sqrt_done) state_in = ST_UNIT_GO;
         ST_UNIT_GO: begin
            if (zflag_ff[vec_ff]) begin
               if (last_comp) state_in = vec_ff ? ST_OUT : ST_DIV_GO;
            end else begin
               state_in = ST_UNIT_WAIT;
            end
         end
         ST_UNIT_WAIT: begin
            if (div_done) begin
               if (last_comp) state_in = vec_ff ? ST_OUT : ST_DIV_GO;
               else state_in = ST_UNIT_GO;
            end
         end
         ST_OUT:       if (rsp_accept) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      div_start  = 1'b0;
      sqrt_start = 1'b0;
      case (state_ff)
         ST_IDLE:    req_stall = 1'b0;
         ST_DIV_GO:  div_start = 1'b1;
         ST_SQRT_GO: sqrt_start = 1'b1;
         ST_UNIT_GO: div_start = !zflag_ff[vec_ff];
         ST_OUT:     rsp_valid = 1'b1;
         default:    req_stall = 1'b1;
      endcase
   end

   // datapath and counters
   always_comb begin
      count_in   = count_ff;
      min_len_in = min_len_ff;
      op_in      = op_ff;
      comp_in    = comp_ff;
      vec_in     = vec_ff;
      pos0_in    = pos0_ff;
      pos1_in    = pos1_ff;
      u0_in      = u0_ff;
      v0_in      = v0_ff;
      u1_in      = u1_ff;
      v1_in      = v1_ff;
      e1_in      = e1_ff;
      e2_in      = e2_ff;
      s1_in      = s1_ff;
      t1_in      = t1_ff;
      s2_in      = s2_ff;
      t2_in      = t2_ff;
      acc_in     = acc_ff;
      num_in     = num_ff;
      det_in     = det_ff;
      mag_in     = mag_ff;
      sum_in     = sum_ff;
      len_in     = len_ff;
      zflag_in   = zflag_ff;
      deg_in     = deg_ff;
      out_in     = out_ff;

      if (csr_write && paddr[2] == 1'(CSR_MIN_LENGTH)) min_len_in = pwdata[15:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (count_ff == 2'd0) begin
                  // hold the first corner
                  pos0_in[0] = req_pos_x;
                  pos0_in[1] = req_pos_y;
                  pos0_in[2] = req_pos_z;
                  u0_in      = req_tex_u;
                  v0_in      = req_tex_v;
                  count_in   = 2'd1;
               end else if (count_ff == 2'd1) begin
                  pos1_in[0] = req_pos_x;
                  pos1_in[1] = req_pos_y;
                  pos1_in[2] = req_pos_z;
                  u1_in      = req_tex_u;
                  v1_in      = req_tex_v;
                  count_in   = 2'd2;
               end else begin
                  // third corner: form edges and UV deltas, clear the result
                  for (int i = 0; i < 3; i++) begin
                     e1_in[i] = 33'(pos1_ff[i]) - 33'(pos0_ff[i]);
                  end
                  e2_in[0] = 33'(req_pos_x) - 33'(pos0_ff[0]);
                  e2_in[1] = 33'(req_pos_y) - 33'(pos0_ff[1]);
                  e2_in[2] = 33'(req_pos_z) - 33'(pos0_ff[2]);
                  s1_in    = 21'(u1_ff) - 21'(u0_ff);
                  t1_in    = 21'(v1_ff) - 21'(v0_ff);
                  s2_in    = 21'(req_tex_u) - 21'(u0_ff);
                  t2_in    = 21'(req_tex_v) - 21'(v0_ff);
                  for (int i = 0; i < 6; i++) begin
                     out_in[i] = '0;
                  end
                  zflag_in = '0;
                  deg_in   = 1'b0;
                  op_in    = '0;
                  comp_in  = '0;
                  vec_in   = 1'b0;
                  count_in = 2'd0;
               end
            end
         end
         ST_MUL_B: begin
            if (!odd_op) begin
               acc_in = 56'(mul_prod);
            end else if (pair_sel == 3'd0) begin
               det_in = 44'(acc_diff);
            end else begin
               num_in[3'(pair_sel - 3'd1)] = acc_diff;
            end
            op_in = op_ff + 4'd1;
            if (op_ff == 4'd13) deg_in = (det_ff == '0);
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               mag_in[comp_ff] = div_quot;
               comp_in         = last_comp ? 2'd0 : comp_ff + 2'd1;
               if (last_comp) sum_in = '0;
            end
         end
         ST_SQ_B: begin
            sum_in  = sum_ff + 64'(mul_prod);
            comp_in = last_comp ? 2'd0 : comp_ff + 2'd1;
         end
         ST_SQRT_WAIT: begin
            if (sqrt_done) begin
               len_in           = sqrt_root;
               zflag_in[vec_ff] = (sqrt_root == '0) || (sqrt_root < 32'(min_len_ff));
            end
         end
         ST_UNIT_GO: begin
            // a zeroed vector keeps its cleared components
            if (zflag_ff[vec_ff]) begin
               comp_in = last_comp ? 2'd0 : comp_ff + 2'd1;
               if (last_comp) vec_in = 1'b1;
            end
         end
         ST_UNIT_WAIT: begin
            if (div_done) begin
               out_in[slot] = unit_val;
               comp_in      = last_comp ? 2'd0 : comp_ff + 2'd1;
               if (last_comp) vec_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= 2'd0;
         min_len_ff <= MIN_LENGTH_RESET;
         op_ff      <= '0;
         comp_ff    <= '0;
         vec_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         min_len_ff <= min_len_in;
         op_ff      <= op_in;
         comp_ff    <= comp_in;
         vec_ff     <= vec_in;
      end
      pos0_ff  <= pos0_in;
      pos1_ff  <= pos1_in;
      u0_ff    <= u0_in;
      v0_ff    <= v0_in;
      u1_ff    <= u1_in;
      v1_ff    <= v1_in;
      e1_ff    <= e1_in;
      e2_ff    <= e2_in;
      s1_ff    <= s1_in;
      t1_ff    <= t1_in;
      s2_ff    <= s2_in;
      t2_ff    <= t2_in;
      acc_ff   <= acc_in;
      num_ff   <= num_in;
      det_ff   <= det_in;
      mag_ff   <= mag_in;
      sum_ff   <= sum_in;
      len_ff   <= len_in;
      zflag_ff <= zflag_in;
      deg_ff   <= deg_in;
      out_ff   <= out_in;
   end

   // register read-back
   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'(CSR_MIN_LENGTH)) ? 32'(min_len_ff) : 32'd0;

   assign rsp_tangent_x        = out_ff[0];
   assign rsp_tangent_y        = out_ff[1];
   assign rsp_tangent_z        = out_ff[2];
   assign rsp_bitangent_x      = out_ff[3];
   assign rsp_bitangent_y      = out_ff[4];
   assign rsp_bitangent_z      = out_ff[5];
   assign rsp_uv_degenerate    = deg_ff;
   assign rsp_tangent_zeroed   = zflag_ff[0];
   assign rsp_bitangent_zeroed = zflag_ff[1];

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall))
      else $error("result pending while vertices are taken");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("corner count out of range");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT || state_ff == ST_UNIT_WAIT))
      else $error("divider finished outside a wait state");

   a_deg_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_uv_degenerate) |-> (zflag_ff == 2'b00))
      else $error("degenerate result carries zeroed flags");

   a_third_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && third) |=> (state_ff == ST_MUL_A && count_ff == 2'd0))
      else $error("third corner did not start the sequencer");
`endif

endmodule
